FILE: hw/rtl/sensor_filter_threshold_monitor_core_defines.svh
// assertion macros for the sensor filter threshold monitor
// included by rtl files that carry concurrent assertions, no other dependency
`ifndef SENSOR_FILTER_THRESHOLD_MONITOR_CORE_DEFINES_SVH
`define SENSOR_FILTER_THRESHOLD_MONITOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SFTM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SFTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/sftm_pkg.sv
// shared types and constants of the sensor filter threshold monitor
// no dependencies
`default_nettype none

package sftm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int ID_W        = 8;
   localparam int ID_COUNT    = 2 ** ID_W;
   localparam int COUNT_OUT_W = 16;
   localparam int CNT_EXT_W   = 32;
   localparam int FILL_W      = 2;
   localparam int CLASS_NUM   = 4;
   localparam int CLASS_IDX_W = 2;
   localparam int HIST_W      = 2 * SAMPLE_W;
   localparam int SUM_W       = SAMPLE_W + 2;
   localparam int MODE_W      = 2;
   localparam int LEVEL_W     = 3;
   localparam int FWD_DEPTH   = 3;

   localparam int SENSOR_COUNT_DEF = 256;
   localparam int COUNT_WIDTH_DEF  = 16;

   localparam logic [FILL_W-1:0] FILL_PAIR = 2'd2;
   localparam logic [FILL_W-1:0] FILL_FULL = 2'd3;

   localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

   // divide by three: multiply by ceil(2^17 / 3), exact for magnitudes below 2^17
   localparam int                 DIV3_W     = SUM_W - 1;
   localparam int                 DIV3_SHIFT = 17;
   localparam logic [DIV3_W-1:0]  DIV3_RECIP = 17'd43691;

   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_NONE       = 3'd0,
      LEVEL_WARN_HIGH  = 3'd1,
      LEVEL_ALARM_HIGH = 3'd2,
      LEVEL_WARN_LOW   = 3'd3,
      LEVEL_ALARM_LOW  = 3'd4
   } level_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] warn_low;
      logic [SAMPLE_W-1:0] warn_high;
      logic [SAMPLE_W-1:0] alarm_lo;
      logic [SAMPLE_W-1:0] alarm_hi;
   } thresh_type;

   typedef struct packed {
      logic [FILL_W-1:0]   fill;
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] median;
      logic [SAMPLE_W-1:0] sample;
   } filt_in_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sftm_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// depends on sftm_pkg for default sizes
`default_nettype none

module sftm_ram #(
   parameter int WIDTH = sftm_pkg::HIST_W,
   parameter int DEPTH = sftm_pkg::SENSOR_COUNT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sftm_filter.sv
// filter select: raw sample, truncating mean or median of the stored samples
// depends on sftm_pkg
`default_nettype none

module sftm_filter (
   input  wire logic [sftm_pkg::MODE_W-1:0]   mode,
   input  wire sftm_pkg::filt_in_type         filt_in,
   output      logic [sftm_pkg::SAMPLE_W-1:0] filtered
);

   logic                                 neg;
   logic [sftm_pkg::SUM_W-1:0]           mag;
   logic [2*sftm_pkg::DIV3_W-1:0]        prod;
   logic [sftm_pkg::DIV3_W-1:0]          quot;
   logic [sftm_pkg::DIV3_W-1:0]          third;
   logic [sftm_pkg::SUM_W-1:0]           half_sum;
   logic [sftm_pkg::SAMPLE_W-1:0]        mean;

   always_comb begin
      neg   = filt_in.sum[sftm_pkg::SUM_W-1];
      mag   = neg ? -filt_in.sum : filt_in.sum;
      prod  = mag[sftm_pkg::DIV3_W-1:0] * sftm_pkg::DIV3_RECIP;
      quot  = prod[2*sftm_pkg::DIV3_W-1:sftm_pkg::DIV3_SHIFT];
      third = neg ? -quot : quot;

      // round toward zero on the halved pair sum
      half_sum = filt_in.sum + {{(sftm_pkg::SUM_W-1){1'b0}}, neg};

      if (filt_in.fill == sftm_pkg::FILL_FULL) begin
         mean = third[sftm_pkg::SAMPLE_W-1:0];
      end else if (filt_in.fill == sftm_pkg::FILL_PAIR) begin
         mean = half_sum[sftm_pkg::SAMPLE_W:1];
      end else begin
         mean = filt_in.sample;
      end

      case (mode)
         sftm_pkg::MODE_RAW:    filtered = filt_in.sample;
         sftm_pkg::MODE_MEAN:   filtered = mean;
         sftm_pkg::MODE_MEDIAN: filtered = filt_in.median;
         default:               filtered = filt_in.sample;
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sftm_class.sv
// threshold classifier, warning high first, then alarm high, warning low, alarm low
// depends on sftm_pkg
`default_nettype none

module sftm_class (
   input  wire logic [sftm_pkg::SAMPLE_W-1:0] filtered,
   input  wire sftm_pkg::thresh_type          thresh,
   output      sftm_pkg::level_type           level
);

   logic ge_warn_high;
   logic lt_alarm_high;
   logic le_warn_low;
   logic gt_alarm_low;

   always_comb begin
      ge_warn_high  = $signed(filtered) >= $signed(thresh.warn_high);
      lt_alarm_high = $signed(filtered) <  $signed(thresh.alarm_hi);
      le_warn_low   = $signed(filtered) <= $signed(thresh.warn_low);
      gt_alarm_low  = $signed(filtered) >  $signed(thresh.alarm_lo);

      if (ge_warn_high && lt_alarm_high) begin
         level = sftm_pkg::LEVEL_WARN_HIGH;
      end else if (!lt_alarm_high) begin
         level = sftm_pkg::LEVEL_ALARM_HIGH;
      end else if (le_warn_low && gt_alarm_low) begin
         level = sftm_pkg::LEVEL_WARN_LOW;
      end else if (!gt_alarm_low) begin
         level = sftm_pkg::LEVEL_ALARM_LOW;
      end else begin
         level = sftm_pkg::LEVEL_NONE;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sensor_filter_threshold_monitor_core.sv
// top level of the sensor filter threshold monitor
// depends on sftm_pkg, sftm_ram, sftm_filter, sftm_class and the defines header

// Takes one sample transaction per cycle, back to back, unless a stalled result holds
// the pipeline or the clearing pass runs, and returns one result per sample through
// stages b, c and d into the output register e. Each sensor keeps its last two samples in
// one ram and a fill count plus four saturating class counters in a second ram; every
// sample reads both rams on acceptance and writes them back as it moves down the
// pipeline, and results for the same sensor that are still in flight are forwarded,
// so repeats of one sensor number run at full rate. After reset the block clears every
// row of the counter ram, with req_ready low; csr writes are taken during that time.
// The sensor number is reduced modulo SENSOR_COUNT. The filter mode must only be
// written while no transaction is in flight.
`default_nettype none

`include "sensor_filter_threshold_monitor_core_defines.svh"

module sensor_filter_threshold_monitor_core #(
   parameter int SENSOR_COUNT = sftm_pkg::SENSOR_COUNT_DEF,
   parameter int COUNT_WIDTH  = sftm_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire logic [sftm_pkg::MODE_W-1:0]         csr_wr_data,
   // sample channel
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [sftm_pkg::ID_W-1:0]           req_sensor_num,
   input  wire logic signed [sftm_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic signed [sftm_pkg::SAMPLE_W-1:0] req_warn_low,
   input  wire logic signed [sftm_pkg::SAMPLE_W-1:0] req_warn_high,
   input  wire logic signed [sftm_pkg::SAMPLE_W-1:0] req_alarm_lo_limit,
   input  wire logic signed [sftm_pkg::SAMPLE_W-1:0] req_alarm_hi_limit,
   // result channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [sftm_pkg::SAMPLE_W-1:0] rsp_filtered,
   output      logic [sftm_pkg::LEVEL_W-1:0]        rsp_level_class,
   output      logic [sftm_pkg::COUNT_OUT_W-1:0]    rsp_class_count
);

   localparam int IDX_W    = $clog2(SENSOR_COUNT);
   localparam int FILL_LSB = sftm_pkg::CLASS_NUM * COUNT_WIDTH;
   localparam int STAT_W   = sftm_pkg::FILL_W + FILL_LSB;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

   localparam int SW = sftm_pkg::SAMPLE_W;

   // signed min / max on raw sample bits
   function automatic logic [SW-1:0] max_s(input logic [SW-1:0] a, input logic [SW-1:0] b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

   function automatic logic [SW-1:0] min_s(input logic [SW-1:0] a, input logic [SW-1:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic logic [SW-1:0] med3(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                          input logic [SW-1:0] c);
      return max_s(min_s(a, b), min_s(max_s(a, b), c));
   endfunction

   // config and clearing pass
   logic [sftm_pkg::MODE_W-1:0] mode_ff;
   logic                        clr_active_ff;
   logic [IDX_W-1:0]            clr_addr_ff;
   logic [IDX_W-1:0]            clr_addr_in;

   // sensor number reduction table
   logic [IDX_W-1:0] id_lut [sftm_pkg::ID_COUNT];
   logic [IDX_W-1:0] req_idx;

   logic adv;
   logic accept;

   // stage b: ram data arrives
   logic                         b_valid_ff;
   logic [IDX_W-1:0]             b_idx_ff;
   logic [SW-1:0]                b_sample_ff;
   sftm_pkg::thresh_type         b_thresh_ff;
   logic [sftm_pkg::HIST_W-1:0]  hist_rd;
   logic [STAT_W-1:0]            stat_rd;
   logic [sftm_pkg::HIST_W-1:0]  hist_fwd;
   logic [SW-1:0]                h0;
   logic [SW-1:0]                h1;
   logic [sftm_pkg::FILL_W-1:0]  fill_old;
   sftm_pkg::filt_in_type        c_filt_in;
   logic [sftm_pkg::HIST_W-1:0]  c_hist_in;

   // stage c: filter
   logic                         c_valid_ff;
   logic [IDX_W-1:0]             c_idx_ff;
   logic [sftm_pkg::HIST_W-1:0]  c_hist_ff;
   logic [STAT_W-1:0]            c_row_ff;
   sftm_pkg::filt_in_type        c_filt_ff;
   sftm_pkg::thresh_type         c_thresh_ff;
   logic [SW-1:0]                d_f_in;

   // stage d: classify and counter update
   logic                         d_valid_ff;
   logic [IDX_W-1:0]             d_idx_ff;
   logic [sftm_pkg::FILL_W-1:0]  d_fill_ff;
   logic [STAT_W-1:0]            d_row_ff;
   logic [SW-1:0]                d_f_ff;
   sftm_pkg::thresh_type         d_thresh_ff;
   sftm_pkg::level_type          d_level;
   logic [sftm_pkg::LEVEL_W-1:0] level_m1;
   logic [sftm_pkg::CLASS_IDX_W-1:0] cls_idx;
   logic [STAT_W-1:0]            row_fwd;
   logic [COUNT_WIDTH-1:0]       cnt_old;
   logic [COUNT_WIDTH-1:0]       cnt_new;
   logic [sftm_pkg::CNT_EXT_W-1:0] cnt_ext;
   logic [STAT_W-1:0]            w_row_in;
   logic [sftm_pkg::COUNT_OUT_W-1:0] e_count_in;

   // last three counter ram writes, index 0 newest
   logic                         w_valid_ff [sftm_pkg::FWD_DEPTH];
   logic [IDX_W-1:0]             w_idx_ff   [sftm_pkg::FWD_DEPTH];
   logic [STAT_W-1:0]            w_row_ff   [sftm_pkg::FWD_DEPTH];

   // stage e: output register
   logic                         e_valid_ff;
   logic [SW-1:0]                e_f_ff;
   sftm_pkg::level_type          e_level_ff;
   logic [sftm_pkg::COUNT_OUT_W-1:0] e_count_ff;

   // stat ram write port
   logic                         stat_wr_en;
   logic [IDX_W-1:0]             stat_wr_addr;
   logic [STAT_W-1:0]            stat_wr_data;

   for (genvar i = 0; i < sftm_pkg::ID_COUNT; i++) begin : g_id_lut
      assign id_lut[i] = IDX_W'(i % SENSOR_COUNT);
   end

   assign req_idx = id_lut[req_sensor_num];

   // whole pipeline steps together; a bubble in stage d lets it close up
   assign adv       = !(d_valid_ff && e_valid_ff && !rsp_ready);
   assign req_ready = adv && !clr_active_ff;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------
   // two newest samples per sensor, {older, newer}
   sftm_ram #(
      .WIDTH (sftm_pkg::HIST_W),
      .DEPTH (SENSOR_COUNT)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (adv && b_valid_ff),
      .wr_addr (b_idx_ff),
      .wr_data (c_hist_in),
      .rd_en   (adv),
      .rd_addr (req_idx),
      .rd_data (hist_rd)
   );

   // {fill count, counter 3 .. counter 0} per sensor
   sftm_ram #(
      .WIDTH (STAT_W),
      .DEPTH (SENSOR_COUNT)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (stat_wr_addr),
      .wr_data (stat_wr_data),
      .rd_en   (adv),
      .rd_addr (req_idx),
      .rd_data (stat_rd)
   );

   assign stat_wr_en   = clr_active_ff || (adv && d_valid_ff);
   assign stat_wr_addr = clr_active_ff ? clr_addr_ff : d_idx_ff;
   assign stat_wr_data = clr_active_ff ? '0 : w_row_in;

   // ---------------------------------------------------------------
   // stage b: merge history and fill, build sums and median
   // ---------------------------------------------------------------
   always_comb begin
      // history of the one older same-sensor transaction still unwritten sits in stage c
      hist_fwd = (c_valid_ff && c_idx_ff == b_idx_ff) ? c_hist_ff : hist_rd;
      h0 = hist_fwd[sftm_pkg::HIST_W-1:SW];
      h1 = hist_fwd[SW-1:0];

      // fill count, newest source wins: last ram write, stage d, stage c
      fill_old = stat_rd[STAT_W-1:FILL_LSB];
      if (w_valid_ff[0] && w_idx_ff[0] == b_idx_ff) begin
         fill_old = w_row_ff[0][STAT_W-1:FILL_LSB];
      end
      if (d_valid_ff && d_idx_ff == b_idx_ff) begin
         fill_old = d_fill_ff;
      end
      if (c_valid_ff && c_idx_ff == b_idx_ff) begin
         fill_old = c_filt_ff.fill;
      end

      c_filt_in.fill   = (fill_old == sftm_pkg::FILL_FULL) ? sftm_pkg::FILL_FULL
                                                           : fill_old + 2'd1;
      c_filt_in.sample = b_sample_ff;

      if (c_filt_in.fill == sftm_pkg::FILL_FULL) begin
         c_filt_in.sum    = {{2{h0[SW-1]}}, h0} + {{2{h1[SW-1]}}, h1}
                          + {{2{b_sample_ff[SW-1]}}, b_sample_ff};
         c_filt_in.median = med3(h0, h1, b_sample_ff);
      end else if (c_filt_in.fill == sftm_pkg::FILL_PAIR) begin
         c_filt_in.sum    = {{2{h1[SW-1]}}, h1} + {{2{b_sample_ff[SW-1]}}, b_sample_ff};
         c_filt_in.median = max_s(h1, b_sample_ff);
      end else begin
         c_filt_in.sum    = {{2{b_sample_ff[SW-1]}}, b_sample_ff};
         c_filt_in.median = b_sample_ff;
      end

      c_hist_in = {h1, b_sample_ff};
   end

   // ---------------------------------------------------------------
   // stage c: filter
   // ---------------------------------------------------------------
   sftm_filter u_filter (
      .mode     (mode_ff),
      .filt_in  (c_filt_ff),
      .filtered (d_f_in)
   );

   // ---------------------------------------------------------------
   // stage d: classify, forward counters, saturating increment
   // ---------------------------------------------------------------
   sftm_class u_class (
      .filtered (d_f_ff),
      .thresh   (d_thresh_ff),
      .level    (d_level)
   );

   always_comb begin
      // counter row as left by the three writes made after this row was read
      row_fwd = d_row_ff;
      for (int k = sftm_pkg::FWD_DEPTH - 1; k >= 0; k--) begin
         if (w_valid_ff[k] && w_idx_ff[k] == d_idx_ff) begin
            row_fwd = w_row_ff[k];
         end
      end

      level_m1 = d_level - 3'd1;
      cls_idx  = level_m1[sftm_pkg::CLASS_IDX_W-1:0];
      cnt_old  = row_fwd[cls_idx*COUNT_WIDTH +: COUNT_WIDTH];
      cnt_new  = (&cnt_old) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
      cnt_ext  = sftm_pkg::CNT_EXT_W'(cnt_new);

      w_row_in = row_fwd;
      w_row_in[STAT_W-1:FILL_LSB] = d_fill_ff;
      if (d_level != sftm_pkg::LEVEL_NONE) begin
         w_row_in[cls_idx*COUNT_WIDTH +: COUNT_WIDTH] = cnt_new;
      end

      e_count_in = (d_level == sftm_pkg::LEVEL_NONE) ? '0
                                                     : cnt_ext[sftm_pkg::COUNT_OUT_W-1:0];
   end

   // ---------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------
   assign clr_addr_in = clr_addr_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= sftm_pkg::MODE_RAW;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         d_valid_ff    <= 1'b0;
         e_valid_ff    <= 1'b0;
         for (int k = 0; k < sftm_pkg::FWD_DEPTH; k++) begin
            w_valid_ff[k] <= 1'b0;
         end
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         // clearing pass, one counter row per cycle
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_in;
            if (clr_addr_ff == LAST_IDX) begin
               clr_active_ff <= 1'b0;
            end
         end
         if (adv) begin
            b_valid_ff    <= accept;
            c_valid_ff    <= b_valid_ff;
            d_valid_ff    <= c_valid_ff;
            w_valid_ff[0] <= d_valid_ff;
            for (int k = 1; k < sftm_pkg::FWD_DEPTH; k++) begin
               w_valid_ff[k] <= w_valid_ff[k-1];
            end
         end
         if (rsp_valid && rsp_ready) begin
            e_valid_ff <= 1'b0;
         end
         if (adv && d_valid_ff) begin
            e_valid_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         b_idx_ff    <= req_idx;
         b_sample_ff <= req_sample;
         b_thresh_ff <= '{warn_low:  req_warn_low,
                          warn_high: req_warn_high,
                          alarm_lo:  req_alarm_lo_limit,
                          alarm_hi:  req_alarm_hi_limit};

         c_idx_ff    <= b_idx_ff;
         c_hist_ff   <= c_hist_in;
         c_row_ff    <= stat_rd;
         c_filt_ff   <= c_filt_in;
         c_thresh_ff <= b_thresh_ff;

         d_idx_ff    <= c_idx_ff;
         d_fill_ff   <= c_filt_ff.fill;
         d_row_ff    <= c_row_ff;
         d_f_ff      <= d_f_in;
         d_thresh_ff <= c_thresh_ff;

         w_idx_ff[0] <= d_idx_ff;
         w_row_ff[0] <= w_row_in;
         for (int k = 1; k < sftm_pkg::FWD_DEPTH; k++) begin
            w_idx_ff[k] <= w_idx_ff[k-1];
            w_row_ff[k] <= w_row_ff[k-1];
         end
      end
      if (adv && d_valid_ff) begin
         e_f_ff     <= d_f_ff;
         e_level_ff <= d_level;
         e_count_ff <= e_count_in;
      end
   end

   assign rsp_valid       = e_valid_ff;
   assign rsp_filtered    = e_f_ff;
   assign rsp_level_class = e_level_ff;
   assign rsp_class_count = e_count_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   `SFTM_ASSERT_NOW(a_clr_blocks_req, clock, reset, clr_active_ff, !req_ready, "req taken during clearing pass")
   `SFTM_ASSERT_NOW(a_clr_pipe_empty, clock, reset, clr_active_ff, !b_valid_ff && !c_valid_ff && !d_valid_ff && !e_valid_ff, "transaction in flight during clearing pass")
   `SFTM_ASSERT_NOW(a_fill_nonzero, clock, reset, d_valid_ff, d_fill_ff != '0, "fill count zero after a sample was stored")
   `SFTM_ASSERT_NOW(a_none_count_zero, clock, reset, rsp_valid && rsp_level_class == sftm_pkg::LEVEL_NONE, rsp_class_count == '0, "nonzero count with no class")
   `SFTM_ASSERT_NEXT(a_d_to_e, clock, reset, adv && d_valid_ff, e_valid_ff, "result lost between stage d and output register")

endmodule

`default_nettype wire

FILE: sim/sensor_filter_threshold_monitor_core_tb.sv
`timescale 1ns / 100ps

// self-checking bench for sensor_filter_threshold_monitor_core: directed and random
// traffic, checked against a per-sensor history and counter predictor
// depends on sftm_pkg and the core rtl
module sensor_filter_threshold_monitor_core_tb;
   import sftm_pkg::*;

   localparam int SENSORS         = SENSOR_COUNT_DEF;
   localparam int HIST_DEPTH      = 3;
   localparam int COUNT_MAX       = 2 ** COUNT_WIDTH_DEF - 1;
   localparam int SAMPLE_MAX      = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAMPLE_MIN      = -(2 ** (SAMPLE_W - 1));
   localparam int RESET_CYCLES    = 7;
   localparam int PIPE_LATENCY    = 3;
   localparam int RANDOM_SEGMENTS = 7;
   localparam int SEGMENT_ITEMS   = 250;
   localparam int TIMEOUT_NS      = 2_000_000;

   // the one mode code the block does not define, must behave as unfiltered
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // threshold band used by the directed part
   localparam int BAND_AL = -1000;
   localparam int BAND_WL = -100;
   localparam int BAND_WH = 100;
   localparam int BAND_AH = 1000;

   typedef struct {
      logic [ID_W-1:0]            sensor_num;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] warn_low;
      logic signed [SAMPLE_W-1:0] warn_high;
      logic signed [SAMPLE_W-1:0] alarm_lo_limit;
      logic signed [SAMPLE_W-1:0] alarm_hi_limit;
   } sample_txn;

   typedef struct {
      logic signed [SAMPLE_W-1:0] filtered;
      level_type                  level;
      logic [COUNT_OUT_W-1:0]     count;
   } level_txn;

   // per-sensor history, fill counts and class counters, plus the queue of
   // levels still owed by the block
   class level_scoreboard;
      logic [MODE_W-1:0] filter_mode;
      int                history [SENSORS*HIST_DEPTH];
      int                fill [SENSORS];
      int                counters [SENSORS*CLASS_NUM];
      level_txn          expected_levels [$];
      int                mismatches;

      function new();
         filter_mode = MODE_RAW;
         foreach (history[i]) history[i] = 0;
         foreach (fill[i]) fill[i] = 0;
         foreach (counters[i]) counters[i] = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      // accepted sample: shift history, filter, classify, bump counter
      function void note_sample(sample_txn t);
         int       id;
         int       base;
         int       oldest;
         int       middle;
         int       newest;
         int       lo;
         int       hi;
         int       f;
         int       wl;
         int       wh;
         int       al;
         int       ah;
         int       slot;
         level_txn r;
         id = int'(t.sensor_num) % SENSORS;
         base = id * HIST_DEPTH;
         history[base] = history[base+1];
         history[base+1] = history[base+2];
         history[base+2] = t.sample;
         if (fill[id] < HIST_DEPTH) fill[id]++;
         oldest = history[base];
         middle = history[base+1];
         newest = history[base+2];
         case (filter_mode)
            MODE_MEAN: begin
               // int division truncates toward zero
               if (fill[id] == 3) f = (oldest + middle + newest) / 3;
               else if (fill[id] == 2) f = (middle + newest) / 2;
               else f = newest;
            end
            MODE_MEDIAN: begin
               if (fill[id] == 3) begin
                  lo = (oldest < middle) ? oldest : middle;
                  hi = (oldest > middle) ? oldest : middle;
                  hi = (hi < newest) ? hi : newest;
                  f = (lo > hi) ? lo : hi;
               end else if (fill[id] == 2) begin
                  f = (middle > newest) ? middle : newest;
               end else begin
                  f = newest;
               end
            end
            default: f = newest;
         endcase
         wl = t.warn_low;
         wh = t.warn_high;
         al = t.alarm_lo_limit;
         ah = t.alarm_hi_limit;
         if (f >= wh && f < ah) r.level = LEVEL_WARN_HIGH;
         else if (f >= ah) r.level = LEVEL_ALARM_HIGH;
         else if (f <= wl && f > al) r.level = LEVEL_WARN_LOW;
         else if (f <= al) r.level = LEVEL_ALARM_LOW;
         else r.level = LEVEL_NONE;
         r.filtered = SAMPLE_W'(f);
         r.count = '0;
         if (r.level != LEVEL_NONE) begin
            slot = id*CLASS_NUM + int'(r.level) - 1;
            if (counters[slot] < COUNT_MAX) counters[slot]++;
            r.count = COUNT_OUT_W'(counters[slot]);
         end
         expected_levels.push_back(r);
      endfunction

      function void check_level(logic signed [SAMPLE_W-1:0] filtered,
                                logic [LEVEL_W-1:0] level,
                                logic [COUNT_OUT_W-1:0] count);
         level_txn r;
         if (expected_levels.size() == 0) begin
            $error("result with no sample pending: filtered %0d level %0d count %0d",
                   filtered, level, count);
            mismatches++;
            return;
         end
         r = expected_levels.pop_front();
         if (filtered !== r.filtered) begin
            $error("filtered: expected %0d, actual %0d", r.filtered, filtered);
            mismatches++;
         end
         if (level !== r.level) begin
            $error("level_class: expected %0d, actual %0d", r.level, level);
            mismatches++;
         end
         if (count !== r.count) begin
            $error("class_count: expected %0d, actual %0d", r.count, count);
            mismatches++;
         end
      endfunction
   endclass

   // every block input starts at a known value
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [MODE_W-1:0]          csr_wr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [ID_W-1:0]            req_sensor_num = '0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic signed [SAMPLE_W-1:0] req_warn_low = '0;
   logic signed [SAMPLE_W-1:0] req_warn_high = '0;
   logic signed [SAMPLE_W-1:0] req_alarm_lo_limit = '0;
   logic signed [SAMPLE_W-1:0] req_alarm_hi_limit = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic [LEVEL_W-1:0]         rsp_level_class;
   logic [COUNT_OUT_W-1:0]     rsp_class_count;

   level_scoreboard level_model;

   // idling switches, changed per phase and cleared for the final phase
   bit sender_gaps = 1'b1;
   bit sink_stalls = 1'b1;
   int stall_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sensor_filter_threshold_monitor_core DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sensor_num     (req_sensor_num),
      .req_sample         (req_sample),
      .req_warn_low       (req_warn_low),
      .req_warn_high      (req_warn_high),
      .req_alarm_lo_limit (req_alarm_lo_limit),
      .req_alarm_hi_limit (req_alarm_hi_limit),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered       (rsp_filtered),
      .rsp_level_class    (rsp_level_class),
      .rsp_class_count    (rsp_class_count)
   );

   // result side: check on the handshake edge (pre-edge values), then decide
   // the next ready; the sink stalls in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         level_model.check_level(rsp_filtered, rsp_level_class, rsp_class_count);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
      if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
      if (v < SAMPLE_MIN) return SAMPLE_W'(SAMPLE_MIN);
      return SAMPLE_W'(v);
   endfunction

   function automatic sample_txn make_txn(int id, int s, int wl, int wh, int al, int ah);
      sample_txn t;
      t.sensor_num = ID_W'(id);
      t.sample = clamp16(s);
      t.warn_low = clamp16(wl);
      t.warn_high = clamp16(wh);
      t.alarm_lo_limit = clamp16(al);
      t.alarm_hi_limit = clamp16(ah);
      return t;
   endfunction

   // mostly a small pool of sensors so histories fill and slide, thresholds
   // mostly ordered around the sample so every class shows up
   function automatic sample_txn random_txn(int pool_base);
      sample_txn t;
      int        center;
      if ($urandom_range(0, 99) < 65) t.sensor_num = ID_W'(pool_base + $urandom_range(0, 5));
      else t.sensor_num = ID_W'($urandom);
      case ($urandom_range(0, 9))
         0:       t.sample = clamp16(SAMPLE_MIN);
         1:       t.sample = clamp16(SAMPLE_MAX);
         2:       t.sample = clamp16(int'($urandom_range(0, 1)) - 1);
         3, 4:    t.sample = clamp16(int'($urandom_range(0, 400)) - 200);
         default: t.sample = SAMPLE_W'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) begin
         // unordered thresholds, including overlapping bands
         t.warn_low = SAMPLE_W'($urandom);
         t.warn_high = SAMPLE_W'($urandom);
         t.alarm_lo_limit = SAMPLE_W'($urandom);
         t.alarm_hi_limit = SAMPLE_W'($urandom);
      end else begin
         center = int'(t.sample) + int'($urandom_range(0, 600)) - 300;
         t.warn_low = clamp16(center - int'($urandom_range(0, 800)));
         t.alarm_lo_limit = clamp16(int'(t.warn_low) - int'($urandom_range(0, 800)));
         t.warn_high = clamp16(center + int'($urandom_range(0, 800)));
         t.alarm_hi_limit = clamp16(int'(t.warn_high) + int'($urandom_range(0, 800)));
      end
      return t;
   endfunction

   // one sample transaction, with an optional idle burst in front; valid is
   // only lowered on the edge that starts a burst, never in the step it rises
   task automatic send_txn(input sample_txn t);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sensor_num <= t.sensor_num;
      req_sample <= t.sample;
      req_warn_low <= t.warn_low;
      req_warn_high <= t.warn_high;
      req_alarm_lo_limit <= t.alarm_lo_limit;
      req_alarm_hi_limit <= t.alarm_hi_limit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      level_model.note_sample(t);
   endtask

   // hold off new samples until every result is back and the pipe is empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (level_model.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_filter_mode(input logic [MODE_W-1:0] m);
      csr_wr_data <= m;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      level_model.filter_mode = m;
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int pool_base;
      level_model = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // the block clears its counters now with req_ready low, csr is taken anyway
      write_filter_mode(MODE_RAW);

      // unfiltered: every class, boundaries on the thresholds, field extremes
      send_txn(make_txn(3, 0, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(3, BAND_WH, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(3, BAND_AH - 1, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(3, BAND_AH, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(3, BAND_WL, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(3, BAND_AL + 1, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(3, BAND_AL, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(255, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
      send_txn(make_txn(0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));

      // mean: fill from one to three, negative sums truncate toward zero
      drain_pipeline();
      write_filter_mode(MODE_MEAN);
      send_txn(make_txn(10, SAMPLE_MIN, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(10, SAMPLE_MIN, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(10, SAMPLE_MIN + 1, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(10, SAMPLE_MAX, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(11, -1, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(11, -2, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(12, SAMPLE_MAX, BAND_WL, BAND_WH, BAND_AL, BAND_AH));

      // median: pair takes the larger, then the middle of three as it slides
      drain_pipeline();
      write_filter_mode(MODE_MEDIAN);
      send_txn(make_txn(20, 10, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(20, -5, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(20, 3, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(20, 7, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(10, 0, BAND_WL, BAND_WH, BAND_AL, BAND_AH));

      // spare mode code acts as unfiltered but history keeps moving
      drain_pipeline();
      write_filter_mode(MODE_SPARE);
      send_txn(make_txn(10, 500, BAND_WL, BAND_WH, BAND_AL, BAND_AH));
      send_txn(make_txn(21, -500, BAND_WL, BAND_WH, BAND_AL, BAND_AH));

      // random segments, each under its own mode and idling mix
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         drain_pipeline();
         case (seg)
            0:       write_filter_mode(MODE_MEAN);
            1:       write_filter_mode(MODE_MEDIAN);
            2:       write_filter_mode(MODE_RAW);
            3:       write_filter_mode(MODE_SPARE);
            default: write_filter_mode(MODE_W'($urandom_range(0, 3)));
         endcase
         sender_gaps = ($urandom_range(0, 3) != 0);
         sink_stalls = ($urandom_range(0, 3) != 0);
         pool_base = $urandom_range(0, 250);
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // sender waits for the block to empty out once mid-stream
            if (seg == 1 && n == SEGMENT_ITEMS / 2) drain_pipeline();
            send_txn(random_txn(pool_base));
         end
      end

      // last phase, no idling: back to back traffic, mostly on a small sensor pool
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      drain_pipeline();
      while (!rsp_ready) @(posedge clock);
      write_filter_mode(MODE_MEDIAN);
      pool_base = $urandom_range(0, 250);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
         send_txn(random_txn(pool_base));
      end

      drain_pipeline();
      if (level_model.mismatches == 0 && level_model.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule
